// File: rtl/ferh_pkg.sv
// ----------------------------------------------------------------------------
// ferh_pkg: shared codes for the evicting handle registry
// Operation codes of a request and the width of the external handle field.
// ----------------------------------------------------------------------------
`default_nettype none

package ferh_pkg;

  localparam int unsigned HANDLE_PORT_BITS = 32;

  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_QUERY      = 2'd1;
  localparam logic [1:0] OP_UNREGISTER = 2'd2;
  // Internal code for a request that changes nothing and reports zeros.
  localparam logic [1:0] OP_NONE       = 2'd3;

  typedef struct packed {
    logic found;
    logic evicted_valid;
  } ferh_flags_t;

endpackage

`default_nettype wire

// File: rtl/ferh_cell.sv
// ----------------------------------------------------------------------------
// ferh_cell: one slot of the handle ring
// Holds one stored handle and passes it to its neighbor whenever the ring
// rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module ferh_cell #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fifo_evicting_handle_registry_core.sv
// ----------------------------------------------------------------------------
// fifo_evicting_handle_registry_core: handle table with round-robin eviction
// Register, query and unregister requests operate on a ring of slot cells
// that rotates once per request past a single compare point.
// ----------------------------------------------------------------------------
// One request at a time: a new request is accepted only once the previous
// result has moved into the output register. The slot ring makes one full
// rotation per request so that every slot passes the compare point.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous) empties every slot and parks the pointer at SLOT_COUNT.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_evicting_handle_registry_core #(
  parameter int unsigned SLOT_COUNT  = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] handle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [3:0]       slot_index,
  output logic             evicted_valid,
  output logic [31:0]      evicted_handle
);

  localparam int unsigned SW = (HANDLE_BITS < ferh_pkg::HANDLE_PORT_BITS) ?
                               HANDLE_BITS : ferh_pkg::HANDLE_PORT_BITS;
  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam int unsigned PW = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state;
  logic [IW-1:0] cnt;
  logic [1:0]    op_r;
  logic [SW-1:0] h_r;
  logic [IW-1:0] reg_slot;
  logic [PW-1:0] next_slot;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [SW-1:0] ev;
  logic          start_empty;
  logic          above_f;
  logic [IW-1:0] above_idx;
  logic          below_f;
  logic [IW-1:0] below_idx;

  logic [SW-1:0] ring_q [SLOT_COUNT];
  logic [SW-1:0] tail_in;
  logic          shift;

  logic          accept;
  logic          out_free;
  logic [SW-1:0] h_in;
  logic [PW-1:0] ns_dec;
  logic [IW-1:0] reg_slot_next;
  logic [SW-1:0] head;
  logic          match;
  logic          first;
  logic          occ;
  logic          ns_valid;
  logic [PW-1:0] cnt_ext;
  ferh_pkg::ferh_flags_t flags;

  // The ring rotates toward cell 0; cell 0 is the compare point and its
  // value, possibly rewritten, re-enters at the far end.
  genvar k;
  generate
    for (k = 0; k < SLOT_COUNT; k++) begin : g_cell
      if (k == SLOT_COUNT - 1) begin : g_tail
        ferh_cell #(.WIDTH(SW)) u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .d     (tail_in),
          .q     (ring_q[k])
        );
      end else begin : g_body
        ferh_cell #(.WIDTH(SW)) u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .d     (ring_q[k+1]),
          .q     (ring_q[k])
        );
      end
    end
  endgenerate

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign shift    = (state == ST_SCAN);
  assign h_in     = handle[SW-1:0];

  // The pointer steps down one slot; from slot 0 or the reset position it
  // wraps to the top slot.
  assign ns_dec        = next_slot - PW'(1);
  assign reg_slot_next = ((next_slot == '0) || (next_slot >= PW'(SLOT_COUNT))) ?
                         IW'(SLOT_COUNT - 1) : ns_dec[IW-1:0];

  // At scan step cnt the head cell holds slot cnt; slots pass from the top
  // down, so the first match seen is the highest one.
  assign head     = ring_q[0];
  assign match    = (head == h_r);
  assign first    = match && !hit;
  assign occ      = (head != '0) && !(first && (op_r == ferh_pkg::OP_UNREGISTER));
  assign ns_valid = (next_slot < PW'(SLOT_COUNT));
  assign cnt_ext  = PW'(cnt);

  always_comb begin
    tail_in = head;
    case (op_r)
      ferh_pkg::OP_REGISTER: begin
        if (cnt == reg_slot) begin
          tail_in = h_r;
        end
      end
      ferh_pkg::OP_UNREGISTER: begin
        if (first) begin
          tail_in = '0;
        end
      end
      default: begin
        tail_in = head;
      end
    endcase
  end

  always_comb begin
    flags.found         = hit && ((op_r == ferh_pkg::OP_QUERY) ||
                                  (op_r == ferh_pkg::OP_UNREGISTER));
    flags.evicted_valid = (op_r == ferh_pkg::OP_REGISTER) && (ev != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_slot <= PW'(SLOT_COUNT);
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
            if ((operation == ferh_pkg::OP_REGISTER) && (h_in != '0)) begin
              next_slot <= PW'(reg_slot_next);
            end
          end
        end
        ST_SCAN: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state     <= ST_IDLE;
            // After an unregister that hits, if the pointed slot is left empty,
            // the pointer moves up to the next occupied slot, wrapping.
            if ((op_r == ferh_pkg::OP_UNREGISTER) && hit && ns_valid && start_empty) begin
              if (above_f) begin
                next_slot <= PW'(above_idx);
              end else if (below_f) begin
                next_slot <= PW'(below_idx);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt         <= IW'(SLOT_COUNT - 1);
      h_r         <= h_in;
      reg_slot    <= reg_slot_next;
      hit         <= 1'b0;
      hit_idx     <= '0;
      ev          <= '0;
      start_empty <= 1'b0;
      above_f     <= 1'b0;
      above_idx   <= '0;
      below_f     <= 1'b0;
      below_idx   <= '0;
      case (operation)
        ferh_pkg::OP_REGISTER:   op_r <= (h_in != '0) ? ferh_pkg::OP_REGISTER :
                                                        ferh_pkg::OP_NONE;
        ferh_pkg::OP_QUERY:      op_r <= ferh_pkg::OP_QUERY;
        ferh_pkg::OP_UNREGISTER: op_r <= (h_in != '0) ? ferh_pkg::OP_UNREGISTER :
                                                        ferh_pkg::OP_NONE;
        default:                 op_r <= ferh_pkg::OP_NONE;
      endcase
    end else if (state == ST_SCAN) begin
      cnt <= cnt - IW'(1);
      if (match) begin
        hit <= 1'b1;
      end
      if (first) begin
        hit_idx <= cnt;
      end
      if (cnt == reg_slot) begin
        ev <= head;
      end
      if (cnt_ext == next_slot) begin
        start_empty <= !occ;
      end
      // Scanning downward, the last occupied slot seen above the pointer is
      // the nearest one above it; likewise the lowest one below it.
      if (occ && (cnt_ext > next_slot)) begin
        above_f   <= 1'b1;
        above_idx <= cnt;
      end
      if (occ && (cnt_ext < next_slot)) begin
        below_f   <= 1'b1;
        below_idx <= cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      found          <= flags.found;
      slot_index     <= flags.found ? 4'(hit_idx) : 4'd0;
      evicted_valid  <= flags.evicted_valid;
      evicted_handle <= flags.evicted_valid ? 32'(ev) : 32'd0;
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && (cnt == IW'(SLOT_COUNT - 1)))
    else $error("accepted request did not start a full ring rotation");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (cnt == '0) |=> (state == ST_DONE))
    else $error("scan did not finish after the last slot");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result appeared without a finished scan");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && evicted_valid))
    else $error("result reports both a match and an eviction");

  a_pointer_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (next_slot <= PW'(SLOT_COUNT)))
    else $error("slot pointer out of range");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the evicting handle registry core
// A directed table followed by phased random traffic drives register, query
// and unregister requests through a valid/ready channel with random gaps.
// Every result is compared field by field against a typed table value or an
// in-bench model of the slot table and its downward-counting eviction pointer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS = 630;
  // Settle time after the last result, before the verdict is printed.
  localparam int SETTLE_CYCLES = 2 * (SLOTS + 2);

  typedef struct packed {
    logic        found;
    logic [3:0]  slot_index;
    logic        evicted_valid;
    logic [31:0] evicted_handle;
  } registry_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] h;
    logic        typed;
    logic        found;
    logic [3:0]  idx;
    logic        ev;
    logic [31:0] evh;
  } directed_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = ferh_pkg::OP_REGISTER;
  logic [31:0] handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [3:0]  slot_index;
  logic        evicted_valid;
  logic [31:0] evicted_handle;

  logic [31:0]      slot_model [SLOTS];
  logic [4:0]       ring_ptr;
  registry_result_t pending_results [$];
  logic [31:0]      live_handles [$];
  directed_row_t    directed_rows [DIRECTED_ROWS];
  int unsigned      mismatch_count = 0;
  bit               sender_eager = 1'b0;
  bit               receiver_eager = 1'b0;

  fifo_evicting_handle_registry_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .handle         (handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .slot_index     (slot_index),
    .evicted_valid  (evicted_valid),
    .evicted_handle (evicted_handle)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int highest_slot_of(logic [31:0] h);
    int i;
    for (i = SLOTS - 1; i >= 0; i--) begin
      if (slot_model[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic registry_result_t predict_registry(logic [1:0] op, logic [31:0] h);
    registry_result_t r;
    int               hit;
    logic [4:0]       start;
    r = '0;
    case (op)
      ferh_pkg::OP_REGISTER: begin
        if (h != 0) begin
          if (ring_ptr == 0 || ring_ptr > SLOTS) ring_ptr = 5'(SLOTS - 1);
          else ring_ptr = ring_ptr - 5'd1;
          r.evicted_valid  = (slot_model[ring_ptr] != 0);
          r.evicted_handle = slot_model[ring_ptr];
          slot_model[ring_ptr] = h;
        end
      end
      ferh_pkg::OP_QUERY: begin
        hit = highest_slot_of(h);
        if (hit >= 0) begin
          r.found      = 1'b1;
          r.slot_index = hit[3:0];
        end
      end
      ferh_pkg::OP_UNREGISTER: begin
        hit = (h == 0) ? -1 : highest_slot_of(h);
        if (hit >= 0) begin
          slot_model[hit] = '0;
          r.found      = 1'b1;
          r.slot_index = hit[3:0];
          // The pointer walks upward past empty slots, at most one full lap.
          if (ring_ptr < SLOTS && slot_model[ring_ptr] == 0) begin
            start = ring_ptr;
            do begin
              if (ring_ptr == SLOTS - 1) ring_ptr = '0;
              else ring_ptr = ring_ptr + 5'd1;
            end while (slot_model[ring_ptr] == 0 && ring_ptr != start);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(bit eager);
    return eager ? 0 : $urandom_range(0, 17);
  endfunction

  // Most handles come from the set registered recently, so that queries and
  // unregisters hit and duplicates build up.
  function automatic logic [31:0] pick_handle();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55 && live_handles.size() != 0)
      return live_handles[$urandom_range(0, live_handles.size() - 1)];
    else if (k < 65) return '0;
    else if (k < 72) return 32'hFFFF_FFFF;
    else if (k < 76) return 32'h1 << $urandom_range(0, 31);
    else if (k < 80) return ~(32'h1 << $urandom_range(0, 31));
    else if (k < 88) return $urandom_range(1, 6);
    return $urandom();
  endfunction

  task automatic issue_request(input logic [1:0] op, input logic [31:0] h,
                               input bit has_typed, input registry_result_t typed_want);
    int               gap;
    registry_result_t model;
    gap = pick_gap(sender_eager);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    handle    <= h;
    do @(posedge clk); while (!in_ready);
    model = predict_registry(op, h);
    pending_results.push_back(has_typed ? typed_want : model);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls on out_ready, checked against the oldest request.
  initial begin
    int               stall;
    registry_result_t want;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_eager = ~receiver_eager;
      stall = pick_gap(receiver_eager);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $display("%0t ERROR: result with no request outstanding", $time);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) begin
          $display("%0t ERROR: found expected %0b actual %0b", $time, want.found, found);
          mismatch_count++;
        end
        if (slot_index !== want.slot_index) begin
          $display("%0t ERROR: slot_index expected %0d actual %0d",
                   $time, want.slot_index, slot_index);
          mismatch_count++;
        end
        if (evicted_valid !== want.evicted_valid) begin
          $display("%0t ERROR: evicted_valid expected %0b actual %0b",
                   $time, want.evicted_valid, evicted_valid);
          mismatch_count++;
        end
        if (evicted_handle !== want.evicted_handle) begin
          $display("%0t ERROR: evicted_handle expected %h actual %h",
                   $time, want.evicted_handle, evicted_handle);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    int               i;
    int               k;
    int               phase;
    int               reg_w;
    int               qry_w;
    logic [1:0]       op;
    logic [31:0]      h;
    registry_result_t want;

    for (i = 0; i < SLOTS; i++) slot_model[i] = '0;
    ring_ptr = 5'(SLOTS);

    // op, handle, typed, found, slot_index, evicted_valid, evicted_handle
    directed_rows = '{
      '{ferh_pkg::OP_QUERY,      32'h0000_0000, 1'b1, 1'b1, 4'd15, 1'b0, 32'h0},
      '{ferh_pkg::OP_QUERY,      32'hFFFF_FFFF, 1'b1, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_REGISTER,   32'h0000_0000, 1'b1, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_UNREGISTER, 32'h0000_0000, 1'b1, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_UNREGISTER, 32'h1234_5678, 1'b1, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_NONE,       32'hFFFF_FFFF, 1'b1, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_REGISTER,   32'hFFFF_FFFF, 1'b1, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_REGISTER,   32'h0000_0001, 1'b1, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_QUERY,      32'hFFFF_FFFF, 1'b1, 1'b1, 4'd15, 1'b0, 32'h0},
      '{ferh_pkg::OP_QUERY,      32'h0000_0001, 1'b1, 1'b1, 4'd14, 1'b0, 32'h0},
      '{ferh_pkg::OP_REGISTER,   32'h0000_0001, 1'b0, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_QUERY,      32'h0000_0001, 1'b1, 1'b1, 4'd14, 1'b0, 32'h0},
      '{ferh_pkg::OP_QUERY,      32'h0000_0000, 1'b1, 1'b1, 4'd12, 1'b0, 32'h0},
      '{ferh_pkg::OP_UNREGISTER, 32'h0000_0001, 1'b0, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_UNREGISTER, 32'h0000_0001, 1'b0, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_REGISTER,   32'hA5A5_A5A5, 1'b0, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_UNREGISTER, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_UNREGISTER, 32'hA5A5_A5A5, 1'b0, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_REGISTER,   32'h8000_0000, 1'b0, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_QUERY,      32'h8000_0000, 1'b0, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_NONE,       32'h8000_0000, 1'b1, 1'b0, 4'd0,  1'b0, 32'h0},
      '{ferh_pkg::OP_QUERY,      32'h5A5A_5A5A, 1'b0, 1'b0, 4'd0,  1'b0, 32'h0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      want = '{directed_rows[i].found, directed_rows[i].idx,
               directed_rows[i].ev, directed_rows[i].evh};
      issue_request(directed_rows[i].op, directed_rows[i].h, directed_rows[i].typed, want);
    end
    hold_until_drained();

    // Phases alternate between filling the table, mixed traffic and draining it.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) hold_until_drained();
      if ($urandom_range(0, 39) == 0) sender_eager = ~sender_eager;
      phase = (i / 80) % 4;
      case (phase)
        0:       begin reg_w = 50; qry_w = 25; end
        1:       begin reg_w = 35; qry_w = 30; end
        2:       begin reg_w = 15; qry_w = 25; end
        default: begin reg_w = 35; qry_w = 35; end
      endcase
      k = $urandom_range(0, 99);
      if (k < reg_w) op = ferh_pkg::OP_REGISTER;
      else if (k < reg_w + qry_w) op = ferh_pkg::OP_QUERY;
      else if (k < 95) op = ferh_pkg::OP_UNREGISTER;
      else op = ferh_pkg::OP_NONE;
      h = pick_handle();
      if (op == ferh_pkg::OP_REGISTER && h != 0) begin
        live_handles.push_back(h);
        if (live_handles.size() > 20) void'(live_handles.pop_front());
      end
      issue_request(op, h, 1'b0, '0);
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
